// ===== rtl/ventilator_alarm_manager_core_macros.svh =====
`ifndef VENTILATOR_ALARM_MANAGER_CORE_MACROS_SVH
`define VENTILATOR_ALARM_MANAGER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define VAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define VAM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define VAM_ASSERT(lbl, prop, msg)

`define VAM_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/vam_pkg.sv =====
package vam_pkg;

  localparam int SAMPLE_BITS      = 16;
  localparam int FAULT_LIMIT_DEF  = 2;
  localparam int POS_BITS         = 32;
  localparam int ALARM_BITS       = 7;
  localparam int TIMER_BITS       = 21;
  localparam int CFG_INDEX_BITS   = 3;
  localparam int CFG_DATA_BITS    = 21;
  localparam int LIMIT_BITS       = 16;
  localparam int CMP_BITS         = 34;

  localparam int BIT_HIGH_PIP  = 0;
  localparam int BIT_LOW_PIP   = 1;
  localparam int BIT_HIGH_PEEP = 2;
  localparam int BIT_LOW_PEEP  = 3;
  localparam int BIT_MECH      = 4;
  localparam int BIT_HIGH_RATE = 5;
  localparam int BIT_FAIL      = 6;

  typedef enum logic [2:0] {
    KIND_PIP     = 3'd0,
    KIND_PEEP    = 3'd1,
    KIND_RATE    = 3'd2,
    KIND_MOTOR   = 3'd3,
    KIND_TICK    = 3'd4,
    KIND_MANAGER = 3'd5,
    KIND_BREATH  = 3'd6,
    KIND_BUTTON  = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_REZERO = 2'd1,
    MODE_FAIL   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_HIGH_PIP  = 3'd0,
    REG_LOW_PIP   = 3'd1,
    REG_HIGH_PEEP = 3'd2,
    REG_LOW_PEEP  = 3'd3,
    REG_HIGH_RATE = 3'd4,
    REG_POS_TOL   = 3'd5,
    REG_SILENCE   = 3'd6
  } reg_index_t;

  localparam logic [2:0] DISP_PRESSURES = 3'd0;
  localparam logic [2:0] DISP_FAIL      = 3'd1;
  localparam logic [2:0] DISP_CAL       = 3'd2;
  localparam logic [2:0] DISP_HIGH_PIP  = 3'd3;
  localparam logic [2:0] DISP_LOW_PEEP  = 3'd4;
  localparam logic [2:0] DISP_HIGH_PEEP = 3'd5;
  localparam logic [2:0] DISP_LOW_PIP   = 3'd6;
  localparam logic [2:0] DISP_HIGH_RATE = 3'd7;

  localparam logic signed [LIMIT_BITS-1:0] HIGH_PIP_RESET  = 16'sd10240;
  localparam logic signed [LIMIT_BITS-1:0] LOW_PIP_RESET   = 16'sd1280;
  localparam logic signed [LIMIT_BITS-1:0] HIGH_PEEP_RESET = 16'sd5120;
  localparam logic signed [LIMIT_BITS-1:0] LOW_PEEP_RESET  = 16'sd768;
  localparam logic [LIMIT_BITS-1:0]        HIGH_RATE_RESET = 16'd8960;
  localparam logic [LIMIT_BITS-1:0]        POS_TOL_RESET   = 16'd100;
  localparam logic [TIMER_BITS-1:0]        SILENCE_RESET   = 21'd120000;

  typedef struct packed {
    kind_t                         kind;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic signed [POS_BITS-1:0]    motor_position;
    logic signed [POS_BITS-1:0]    target_position;
  } in_item_t;

  typedef struct packed {
    logic [ALARM_BITS-1:0] check_bits;
    logic [ALARM_BITS-1:0] active_alarms;
    logic                  buzzer_on;
    logic                  led_on;
    mode_t                 mode_request;
    logic [2:0]            display_code;
  } out_item_t;

  function automatic logic [2:0] display_of(input logic [ALARM_BITS-1:0] a);
    logic [2:0] code;
    code = DISP_PRESSURES;
    if (a[BIT_FAIL])           code = DISP_FAIL;
    else if (a[BIT_MECH])      code = DISP_CAL;
    else if (a[BIT_HIGH_PIP])  code = DISP_HIGH_PIP;
    else if (a[BIT_LOW_PEEP])  code = DISP_LOW_PEEP;
    else if (a[BIT_HIGH_PEEP]) code = DISP_HIGH_PEEP;
    else if (a[BIT_LOW_PIP])   code = DISP_LOW_PIP;
    else if (a[BIT_HIGH_RATE]) code = DISP_HIGH_RATE;
    return code;
  endfunction

endpackage

// ===== rtl/ventilator_alarm_manager_core.sv =====
// Ventilator alarm manager. Every item on the input channel yields exactly one result
// and one item is accepted per clock: a check, tick, manager pass, breath end or reset
// button press updates the alarm state in the cycle it transfers, and its result is
// written into a two-entry output queue. Input transfers continue while fewer than two
// results wait and stall while both entries are full. Results leave in input order,
// the earliest in the cycle after their item, so with an output side that never stalls
// one item passes per cycle. Configuration writes are accepted every cycle and take
// effect for the next item; writes to index 7 are dropped.
`include "ventilator_alarm_manager_core_macros.svh"

module ventilator_alarm_manager_core #(
  parameter int FAULT_LIMIT = vam_pkg::FAULT_LIMIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  vam_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output vam_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vam_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [vam_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int AB = vam_pkg::ALARM_BITS;
  localparam int TB = vam_pkg::TIMER_BITS;
  localparam int CB = vam_pkg::CMP_BITS;
  localparam int LB = vam_pkg::LIMIT_BITS;

  logic signed [LB-1:0] high_pip_limit, low_pip_limit, high_peep_limit, low_peep_limit;
  logic [LB-1:0]        high_rate_limit, motor_tolerance;
  logic [TB-1:0]        silence_time_ms;

  logic [AB-1:0] pending_bits, breath_bits, previous_breath_bits, alarm_bits, silenced_bits;
  logic [1:0]    fault_count;
  logic [TB-1:0] silence_elapsed;
  logic          reset_pending, buzzer_level, led_level;

  logic [AB-1:0] pending_bits_next, breath_bits_next, previous_breath_bits_next;
  logic [AB-1:0] alarm_bits_next, silenced_bits_next;
  logic [1:0]    fault_count_next;
  logic [TB-1:0] silence_elapsed_next;
  logic          reset_pending_next, buzzer_level_next, led_level_next;

  vam_pkg::out_item_t q0, q1, result;
  logic [1:0]         count;
  logic               push, pop;

  logic [AB-1:0]        found;
  vam_pkg::mode_t       mode;
  logic signed [CB-1:0] s_ext, diff, tol_ext;
  logic [1:0]           fc_inc;
  logic [AB-1:0]        pend_m, sil_tmp;
  logic                 timed_out;

  assign cfg_ready = 1'b1;
  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = q0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_pip_limit     <= vam_pkg::HIGH_PIP_RESET;
      low_pip_limit      <= vam_pkg::LOW_PIP_RESET;
      high_peep_limit    <= vam_pkg::HIGH_PEEP_RESET;
      low_peep_limit     <= vam_pkg::LOW_PEEP_RESET;
      high_rate_limit    <= vam_pkg::HIGH_RATE_RESET;
      motor_tolerance    <= vam_pkg::POS_TOL_RESET;
      silence_time_ms    <= vam_pkg::SILENCE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vam_pkg::REG_HIGH_PIP:  high_pip_limit     <= cfg_data[LB-1:0];
        vam_pkg::REG_LOW_PIP:   low_pip_limit      <= cfg_data[LB-1:0];
        vam_pkg::REG_HIGH_PEEP: high_peep_limit    <= cfg_data[LB-1:0];
        vam_pkg::REG_LOW_PEEP:  low_peep_limit     <= cfg_data[LB-1:0];
        vam_pkg::REG_HIGH_RATE: high_rate_limit    <= cfg_data[LB-1:0];
        vam_pkg::REG_POS_TOL:   motor_tolerance    <= cfg_data[LB-1:0];
        vam_pkg::REG_SILENCE:   silence_time_ms    <= cfg_data[TB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    s_ext   = CB'(in_data.sample_value);
    diff    = CB'(in_data.motor_position) - CB'(in_data.target_position);
    tol_ext = CB'($signed({1'b0, motor_tolerance}));
    fc_inc  = (fault_count != 2'd3) ? fault_count + 2'd1 : fault_count;

    found = '0;
    mode  = vam_pkg::MODE_NONE;
    pend_m    = pending_bits;
    sil_tmp   = silenced_bits;
    timed_out = 1'b0;

    pending_bits_next         = pending_bits;
    breath_bits_next          = breath_bits;
    previous_breath_bits_next = previous_breath_bits;
    alarm_bits_next           = alarm_bits;
    silenced_bits_next        = silenced_bits;
    fault_count_next          = fault_count;
    silence_elapsed_next      = silence_elapsed;
    reset_pending_next        = reset_pending;
    buzzer_level_next         = buzzer_level;
    led_level_next            = led_level;

    unique case (in_data.kind)
      vam_pkg::KIND_PIP: begin
        found[vam_pkg::BIT_HIGH_PIP] = s_ext > CB'(high_pip_limit);
        found[vam_pkg::BIT_LOW_PIP]  = s_ext < CB'(low_pip_limit);
      end
      vam_pkg::KIND_PEEP: begin
        found[vam_pkg::BIT_HIGH_PEEP] = s_ext > CB'(high_peep_limit);
        found[vam_pkg::BIT_LOW_PEEP]  = s_ext < CB'(low_peep_limit);
      end
      vam_pkg::KIND_RATE: begin
        found[vam_pkg::BIT_HIGH_RATE] = s_ext > CB'($signed({1'b0, high_rate_limit}));
      end
      vam_pkg::KIND_MOTOR: begin
        found[vam_pkg::BIT_MECH] = (diff > tol_ext) || (diff < -tol_ext);
      end
      vam_pkg::KIND_TICK: begin
        if (silence_elapsed != '1) silence_elapsed_next = silence_elapsed + TB'(1);
      end
      vam_pkg::KIND_MANAGER: begin
        if (pending_bits[vam_pkg::BIT_MECH]) begin
          fault_count_next = fc_inc;
          if (fc_inc >= 2'(FAULT_LIMIT)) begin
            mode = vam_pkg::MODE_FAIL;
            pend_m[vam_pkg::BIT_FAIL] = 1'b1;
          end else begin
            mode = vam_pkg::MODE_REZERO;
          end
        end
        breath_bits_next  = breath_bits | pend_m;
        pending_bits_next = '0;
        alarm_bits_next   = alarm_bits | breath_bits_next;
        if (alarm_bits_next != '0) begin
          if (reset_pending) begin
            reset_pending_next   = 1'b0;
            silence_elapsed_next = '0;
            sil_tmp              = alarm_bits_next;
          end
          timed_out = silence_elapsed_next > silence_time_ms;
          silenced_bits_next = timed_out ? '0 : sil_tmp;
          buzzer_level_next  = timed_out || ((alarm_bits_next & ~sil_tmp) != '0);
          led_level_next     = 1'b1;
        end else begin
          buzzer_level_next = 1'b0;
          led_level_next    = 1'b0;
        end
      end
      vam_pkg::KIND_BREATH: begin
        alarm_bits_next           = breath_bits | previous_breath_bits;
        previous_breath_bits_next = breath_bits;
        breath_bits_next          = '0;
      end
      vam_pkg::KIND_BUTTON: begin
        reset_pending_next = 1'b1;
      end
      default: ;
    endcase

    pending_bits_next = pending_bits_next | found;

    result.check_bits    = found;
    result.active_alarms = alarm_bits_next;
    result.buzzer_on     = buzzer_level_next;
    result.led_on        = led_level_next;
    result.mode_request  = mode;
    result.display_code  = vam_pkg::display_of(alarm_bits_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits         <= '0;
      breath_bits          <= '0;
      previous_breath_bits <= '0;
      alarm_bits           <= '0;
      silenced_bits        <= '0;
      fault_count          <= '0;
      silence_elapsed      <= '0;
      reset_pending        <= 1'b0;
      buzzer_level         <= 1'b0;
      led_level            <= 1'b0;
    end else if (push) begin
      pending_bits         <= pending_bits_next;
      breath_bits          <= breath_bits_next;
      previous_breath_bits <= previous_breath_bits_next;
      alarm_bits           <= alarm_bits_next;
      silenced_bits        <= silenced_bits_next;
      fault_count          <= fault_count_next;
      silence_elapsed      <= silence_elapsed_next;
      reset_pending        <= reset_pending_next;
      buzzer_level         <= buzzer_level_next;
      led_level            <= led_level_next;
    end
  end

  // two-entry result queue, head in q0
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) q0 <= result;
      else q1 <= result;
    end else if (pop && !push) begin
      q0 <= q1;
    end else if (push && pop) begin
      if (count == 2'd1) begin
        q0 <= result;
      end else begin
        q0 <= q1;
        q1 <= result;
      end
    end
  end

  `VAM_ASSERT_ALWAYS(a_queue_bound, rst || (count != 2'd3), "result queue overflow")
  `VAM_ASSERT(a_buzzer_needs_led, buzzer_level |-> led_level, "buzzer on with LED off")
  `VAM_ASSERT(a_led_tracks_alarm, $past(push && in_data.kind == vam_pkg::KIND_MANAGER) |-> (led_level == (alarm_bits != '0)), "LED level disagrees with alarms after manager pass")
  `VAM_ASSERT(a_mode_has_alarm, (out_valid && out_data.mode_request != vam_pkg::MODE_NONE) |-> out_data.active_alarms[vam_pkg::BIT_MECH], "mode request without mechanical alarm")
  `VAM_ASSERT(a_fail_mode_flag, (out_valid && out_data.mode_request == vam_pkg::MODE_FAIL) |-> out_data.active_alarms[vam_pkg::BIT_FAIL], "failure mode without failure alarm")

endmodule

// ===== bench/alarm_checker.sv =====
module alarm_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  vam_pkg::in_item_t                   in_data,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  vam_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [vam_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [vam_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output int                                  failures,
  output int                                  awaiting
);
  import vam_pkg::*;

  localparam logic [TIMER_BITS-1:0] QUIET_MAX = '1;

  localparam int DISPLAY_RANK [ALARM_BITS] = '{BIT_FAIL, BIT_MECH, BIT_HIGH_PIP,
    BIT_LOW_PEEP, BIT_HIGH_PEEP, BIT_LOW_PIP, BIT_HIGH_RATE};
  localparam logic [2:0] DISPLAY_CODE [ALARM_BITS] = '{DISP_FAIL, DISP_CAL,
    DISP_HIGH_PIP, DISP_LOW_PEEP, DISP_HIGH_PEEP, DISP_LOW_PIP, DISP_HIGH_RATE};

  logic signed [LIMIT_BITS-1:0] pip_hi, pip_lo, peep_hi, peep_lo;
  logic [LIMIT_BITS-1:0]        rate_hi, pos_tol;
  logic [TIMER_BITS-1:0]        silence_ms;

  logic [ALARM_BITS-1:0] held_bits, breath_now, breath_prev, active_set, muted_bits;
  logic [1:0]            fault_hits;
  logic [TIMER_BITS-1:0] quiet_ms;
  logic                  ack_latched, buzzer_state, led_state;

  out_item_t alarm_results[$];

  initial begin
    failures = 0;
    awaiting = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: alarm result mismatch: %s", $time, msg);
    failures++;
  endtask

  function automatic out_item_t advance_alarms(input in_item_t it);
    out_item_t             r;
    logic [ALARM_BITS-1:0] found;
    mode_t                 mode;
    logic [2:0]            code;
    logic                  timed_out;
    longint                sample, pos, tgt, tol;
    found = '0;
    mode = MODE_NONE;
    sample = longint'(it.sample_value);
    pos = longint'(it.motor_position);
    tgt = longint'(it.target_position);
    tol = longint'(pos_tol);
    case (it.kind)
      KIND_PIP: begin
        if (sample > longint'(pip_hi)) found[BIT_HIGH_PIP] = 1'b1;
        if (sample < longint'(pip_lo)) found[BIT_LOW_PIP] = 1'b1;
      end
      KIND_PEEP: begin
        if (sample > longint'(peep_hi)) found[BIT_HIGH_PEEP] = 1'b1;
        if (sample < longint'(peep_lo)) found[BIT_LOW_PEEP] = 1'b1;
      end
      KIND_RATE: begin
        if (sample > longint'(rate_hi)) found[BIT_HIGH_RATE] = 1'b1;
      end
      KIND_MOTOR: begin
        if (pos > tgt + tol || pos < tgt - tol) found[BIT_MECH] = 1'b1;
      end
      KIND_TICK: begin
        if (quiet_ms != QUIET_MAX) quiet_ms = quiet_ms + TIMER_BITS'(1);
      end
      KIND_MANAGER: begin
        if (held_bits[BIT_MECH]) begin
          if (fault_hits != 2'b11) fault_hits = fault_hits + 2'd1;
          if (fault_hits >= 2'(FAULT_LIMIT_DEF)) begin
            mode = MODE_FAIL;
            held_bits[BIT_FAIL] = 1'b1;
          end else begin
            mode = MODE_REZERO;
          end
        end
        breath_now = breath_now | held_bits;
        held_bits = '0;
        active_set = active_set | breath_now;
        if (active_set != '0) begin
          if (ack_latched) begin
            ack_latched = 1'b0;
            quiet_ms = '0;
            muted_bits = active_set;
          end
          timed_out = quiet_ms > silence_ms;
          if (timed_out || (active_set & ~muted_bits) != '0) begin
            if (timed_out) muted_bits = '0;
            buzzer_state = 1'b1;
          end else begin
            buzzer_state = 1'b0;
          end
          led_state = 1'b1;
        end else begin
          buzzer_state = 1'b0;
          led_state = 1'b0;
        end
      end
      KIND_BREATH: begin
        active_set = breath_now | breath_prev;
        breath_prev = breath_now;
        breath_now = '0;
      end
      KIND_BUTTON: begin
        ack_latched = 1'b1;
      end
    endcase
    held_bits = held_bits | found;

    code = DISP_PRESSURES;
    for (int i = ALARM_BITS - 1; i >= 0; i--) begin
      if (active_set[DISPLAY_RANK[i]]) code = DISPLAY_CODE[i];
    end

    r.check_bits = found;
    r.active_alarms = active_set;
    r.buzzer_on = buzzer_state;
    r.led_on = led_state;
    r.mode_request = mode;
    r.display_code = code;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      pip_hi = HIGH_PIP_RESET;
      pip_lo = LOW_PIP_RESET;
      peep_hi = HIGH_PEEP_RESET;
      peep_lo = LOW_PEEP_RESET;
      rate_hi = HIGH_RATE_RESET;
      pos_tol = POS_TOL_RESET;
      silence_ms = SILENCE_RESET;
      held_bits = '0;
      breath_now = '0;
      breath_prev = '0;
      active_set = '0;
      muted_bits = '0;
      fault_hits = '0;
      quiet_ms = '0;
      ack_latched = 1'b0;
      buzzer_state = 1'b0;
      led_state = 1'b0;
      alarm_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HIGH_PIP:  pip_hi = cfg_data[LIMIT_BITS-1:0];
          REG_LOW_PIP:   pip_lo = cfg_data[LIMIT_BITS-1:0];
          REG_HIGH_PEEP: peep_hi = cfg_data[LIMIT_BITS-1:0];
          REG_LOW_PEEP:  peep_lo = cfg_data[LIMIT_BITS-1:0];
          REG_HIGH_RATE: rate_hi = cfg_data[LIMIT_BITS-1:0];
          REG_POS_TOL:   pos_tol = cfg_data[LIMIT_BITS-1:0];
          REG_SILENCE:   silence_ms = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (alarm_results.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = alarm_results.pop_front();
          if (out_data.check_bits !== want.check_bits)
            report_mismatch($sformatf("check_bits %h, expected %h",
                                      out_data.check_bits, want.check_bits));
          if (out_data.active_alarms !== want.active_alarms)
            report_mismatch($sformatf("active_alarms %h, expected %h",
                                      out_data.active_alarms, want.active_alarms));
          if (out_data.buzzer_on !== want.buzzer_on)
            report_mismatch($sformatf("buzzer_on %b, expected %b",
                                      out_data.buzzer_on, want.buzzer_on));
          if (out_data.led_on !== want.led_on)
            report_mismatch($sformatf("led_on %b, expected %b",
                                      out_data.led_on, want.led_on));
          if (out_data.mode_request !== want.mode_request)
            report_mismatch($sformatf("mode_request %0d, expected %0d",
                                      out_data.mode_request, want.mode_request));
          if (out_data.display_code !== want.display_code)
            report_mismatch($sformatf("display_code %0d, expected %0d",
                                      out_data.display_code, want.display_code));
        end
      end
      if (in_valid && in_ready) alarm_results.push_back(advance_alarms(in_data));
    end
    awaiting = alarm_results.size();
  end

endmodule

// ===== bench/tb.sv =====
module tb;
  import vam_pkg::*;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  in_item_t                  in_data;
  logic                      out_valid;
  logic                      out_ready;
  out_item_t                 out_data;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  int                        failures;
  int                        awaiting;

  int                        idle_pct;
  int                        stall_pct;
  int                        items_sent;
  bit                        hold_request;
  logic [CFG_DATA_BITS-1:0]  setting [8];

  ventilator_alarm_manager_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  alarm_checker scoreboard (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .awaiting  (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (80) @(posedge clk);
        hold_request = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic in_item_t make_item(input kind_t k, input int sample,
                                         input longint pos, input longint tgt);
    in_item_t it;
    it.kind = k;
    it.sample_value = SAMPLE_BITS'(sample);
    it.motor_position = POS_BITS'(pos);
    it.target_position = POS_BITS'(tgt);
    return it;
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    it.kind = kind_t'($urandom_range(int'(KIND_BUTTON)));
    it.sample_value = SAMPLE_BITS'($urandom);
    it.motor_position = $urandom;
    it.target_position = $urandom;
    return it;
  endfunction

  // checks aimed mostly at the configured limits, just below, on and above
  function automatic in_item_t check_item();
    in_item_t                 it;
    logic [CFG_DATA_BITS-1:0] base;
    longint                   dev;
    it = noise_item();
    it.kind = kind_t'($urandom_range(int'(KIND_MOTOR)));
    case (it.kind)
      KIND_PIP:  base = $urandom_range(1) ? setting[REG_HIGH_PIP] : setting[REG_LOW_PIP];
      KIND_PEEP: base = $urandom_range(1) ? setting[REG_HIGH_PEEP] : setting[REG_LOW_PEEP];
      default:   base = setting[REG_HIGH_RATE];
    endcase
    if ($urandom_range(3) != 0) begin
      it.sample_value = SAMPLE_BITS'(base[LIMIT_BITS-1:0] + $urandom_range(2) - 1);
      if (it.kind == KIND_MOTOR) begin
        dev = longint'(setting[REG_POS_TOL][LIMIT_BITS-1:0]) + $urandom_range(2) - 1;
        if ($urandom_range(1)) dev = -dev;
        it.motor_position = POS_BITS'(longint'(it.target_position) + dev);
      end
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_breath();
    repeat ($urandom_range(1, 6)) send_item(check_item());
    repeat ($urandom_range(0, 3)) send_item(make_item(KIND_TICK, $urandom, $urandom, $urandom));
    if ($urandom_range(3) == 0)
      send_item(make_item(KIND_BUTTON, $urandom, $urandom, $urandom));
    send_item(make_item(KIND_MANAGER, $urandom, $urandom, $urandom));
    if ($urandom_range(2) == 0) begin
      repeat ($urandom_range(1, 8)) send_item(make_item(KIND_TICK, $urandom, $urandom, $urandom));
      send_item(make_item(KIND_MANAGER, $urandom, $urandom, $urandom));
    end
    send_item(make_item(KIND_BREATH, $urandom, $urandom, $urandom));
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    setting[idx] = val;
  endtask

  // drop valid, wait out every expected result and the block's latency
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    hold_request = 1'b0;
    setting[REG_HIGH_PIP] = CFG_DATA_BITS'(HIGH_PIP_RESET);
    setting[REG_LOW_PIP] = CFG_DATA_BITS'(LOW_PIP_RESET);
    setting[REG_HIGH_PEEP] = CFG_DATA_BITS'(HIGH_PEEP_RESET);
    setting[REG_LOW_PEEP] = CFG_DATA_BITS'(LOW_PEEP_RESET);
    setting[REG_HIGH_RATE] = CFG_DATA_BITS'(HIGH_RATE_RESET);
    setting[REG_POS_TOL] = CFG_DATA_BITS'(POS_TOL_RESET);
    setting[REG_SILENCE] = SILENCE_RESET;
    setting[7] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(make_item(KIND_PIP, 32767, 0, 0));
    send_item(make_item(KIND_PIP, -32768, 0, 0));
    send_item(make_item(KIND_PIP, 10240, 0, 0));
    send_item(make_item(KIND_PIP, 1280, 0, 0));
    send_item(make_item(KIND_PEEP, 5121, 0, 0));
    send_item(make_item(KIND_PEEP, 767, 0, 0));
    send_item(make_item(KIND_RATE, 8961, 0, 0));
    send_item(make_item(KIND_RATE, -32768, 0, 0));
    send_item(make_item(KIND_RATE, 8960, 0, 0));
    send_item(make_item(KIND_MOTOR, 0, 100, 0));
    send_item(make_item(KIND_MOTOR, 0, -101, 0));
    send_item(make_item(KIND_MANAGER, 0, 0, 0));
    send_item(make_item(KIND_BUTTON, 0, 0, 0));
    send_item(make_item(KIND_BUTTON, -1, -1, -1));
    send_item(make_item(KIND_TICK, 0, 0, 0));
    send_item(make_item(KIND_MANAGER, 0, 0, 0));
    send_item(make_item(KIND_MOTOR, 0, 64'sd2147483647, -64'sd2147483648));
    send_item(make_item(KIND_MANAGER, 0, 0, 0));
    send_item(make_item(KIND_BREATH, 0, 0, 0));
    send_item(make_item(KIND_MANAGER, 0, 0, 0));
    send_item(make_item(KIND_BREATH, 0, 0, 0));
    send_item(make_item(KIND_BREATH, 0, 0, 0));
    send_item(make_item(KIND_MANAGER, 0, 0, 0));

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin
          write_reg(REG_SILENCE, 21'd3);
          write_reg(REG_POS_TOL, CFG_DATA_BITS'($urandom_range(200)));
          write_reg(3'd7, CFG_DATA_BITS'($urandom));
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          write_reg(REG_HIGH_PIP, 21'h07FFF);
          write_reg(REG_LOW_PIP, 21'h08000);
          write_reg(REG_HIGH_PEEP, 21'h07FFF);
          write_reg(REG_LOW_PEEP, 21'h08000);
          write_reg(REG_HIGH_RATE, 21'h0FFFF);
          write_reg(REG_POS_TOL, 21'h0FFFF);
          write_reg(REG_SILENCE, 21'h1FFFFF);
          idle_pct = 49;
          stall_pct = 0;
        end
        2: begin
          write_reg(REG_HIGH_PIP, 21'h1F8000);
          write_reg(REG_LOW_PIP, 21'h1F7FFF);
          write_reg(REG_HIGH_PEEP, 21'h1F8000);
          write_reg(REG_LOW_PEEP, 21'h1F7FFF);
          write_reg(REG_HIGH_RATE, 21'h1F0000);
          write_reg(REG_POS_TOL, 21'h1F0000);
          write_reg(REG_SILENCE, 21'd0);
          idle_pct = 0;
          stall_pct = 49;
        end
        default: begin
          for (int r = 0; r < 6; r++) write_reg(CFG_INDEX_BITS'(r), CFG_DATA_BITS'($urandom));
          write_reg(REG_SILENCE, CFG_DATA_BITS'($urandom_range(20)));
          idle_pct = 34;
          stall_pct = 34;
        end
      endcase
      cfg_valid <= 1'b0;
      @(posedge clk);
      if (phase == 0) hold_request = 1'b1;
      items_sent = 0;
      while (items_sent < 175) begin
        if ($urandom_range(4) == 0) send_item(noise_item());
        else send_breath();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
